// ----- hdl/sida_pkg.sv -----
package sida_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 4;
   localparam int MAG_DIGITS = 10;   // decimal digits of a 32-bit magnitude

   localparam logic [CHAR_W-1:0]  CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'd48;
   localparam logic [DIGIT_W-1:0] RADIX    = 4'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

   // ceil(2^35 / 10): x / 10 == (x * RECIP) >> 35 for any 32-bit x
   localparam logic [2*VALUE_W-1:0] RECIP   = 64'h0000_0000_CCCC_CCCD;
   localparam int                   RECIP_SH = 35;

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] quot;
   } sida_stage_type;

endpackage

// ----- hdl/sida_digit_stage.sv -----
module sida_digit_stage #(
   parameter int NSTG = 10,
   parameter int IDX  = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  sida_pkg::sida_stage_type        in_data,
   input  logic [NSTG*sida_pkg::DIGIT_W-1:0] in_digits,
   output logic                            in_ready,
   output logic                            out_valid,
   output sida_pkg::sida_stage_type        out_data,
   output logic [NSTG*sida_pkg::DIGIT_W-1:0] out_digits,
   input  logic                            out_ready
);
   import sida_pkg::*;

   localparam int QW = 2*VALUE_W - RECIP_SH;

   logic                      valid_ff, valid_in;
   sida_stage_type            data_ff, data_in;
   logic [NSTG*DIGIT_W-1:0]   digits_ff, digits_in;
   logic [2*VALUE_W-1:0]      prod;
   logic [QW-1:0]             quot;
   logic [VALUE_W-1:0]        quot10;
   logic [VALUE_W-1:0]        rem;
   logic                      load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   always_comb begin
      prod    = {{VALUE_W{1'b0}}, in_data.quot} * RECIP;
      quot    = prod[2*VALUE_W-1:RECIP_SH];
      quot10  = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
      rem     = in_data.quot - quot10;
      data_in = '{neg: in_data.neg, quot: VALUE_W'(quot)};
      digits_in = in_digits;
      digits_in[IDX*DIGIT_W +: DIGIT_W] = rem[DIGIT_W-1:0];
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= data_in;
         digits_ff <= digits_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_data   = data_ff;
   assign out_digits = digits_ff;

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text.
// Input channel req_: one word carries req_value (two's complement).
// Result channel rsp_: one word per character, most significant first:
//   '-' for a negative value, then the digits with no leading zeros.
//   rsp_last marks the final character; rsp_char_count holds the total
//   character count on that word and 0 on the others.
// A word is taken on a clock edge with valid high and stall low.
// The first character passes through the input register, one divide-by-10
// stage per digit, the serializer load and the output register.
// The serializer emits one character per cycle while rsp_stall is low and
// loads the next number only after the last character of the current one.
// The digit pipeline fills behind it while it emits.
// Reset (synchronous, active high) empties the pipeline and the output.
// When rsp_stall is high the output word holds and the pipeline backs up
// to req_stall without dropping or repeating anything.
// Magnitudes wider than MAX_DIGITS digits saturate to all nines.
module signed_int_to_decimal_ascii #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sida_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sida_pkg::CHAR_W-1:0]      rsp_character,
   output logic                             rsp_last,
   output logic [sida_pkg::COUNT_W-1:0]     rsp_char_count
);
   import sida_pkg::*;

   localparam int NSTG = (MAX_DIGITS < MAG_DIGITS) ? MAX_DIGITS : MAG_DIGITS;
   localparam int PW   = (NSTG > 1) ? $clog2(NSTG) : 1;
   localparam int NDW  = $clog2(NSTG + 1);

   // pipeline links, index k is register stage k
   logic                    st_valid  [0:NSTG];
   sida_stage_type          st_data   [0:NSTG];
   logic [NSTG*DIGIT_W-1:0] st_digits [0:NSTG];
   logic                    st_ready  [0:NSTG+1];

   // input register
   logic           s0_valid_ff, s0_valid_in;
   sida_stage_type s0_data_ff, s0_data_in;
   logic           s0_load;

   assign st_ready[0] = !s0_valid_ff || st_ready[1];
   assign req_stall   = !st_ready[0];
   assign s0_load     = st_ready[0] && req_valid;

   always_comb begin
      s0_valid_in     = st_ready[0] ? req_valid : s0_valid_ff;
      s0_data_in.neg  = req_value[VALUE_W-1];
      s0_data_in.quot = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_data_ff <= s0_data_in;
      end
   end

   assign st_valid[0]  = s0_valid_ff;
   assign st_data[0]   = s0_data_ff;
   assign st_digits[0] = '0;

   for (genvar g = 0; g < NSTG; g++) begin : g_stage
      sida_digit_stage #(
         .NSTG (NSTG),
         .IDX  (g)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (st_valid[g]),
         .in_data    (st_data[g]),
         .in_digits  (st_digits[g]),
         .in_ready   (st_ready[g+1]),
         .out_valid  (st_valid[g+1]),
         .out_data   (st_data[g+1]),
         .out_digits (st_digits[g+1]),
         .out_ready  (st_ready[g+2])
      );
   end

   // saturation and digit count of the finished word
   logic                    pk_sat;
   logic [NSTG*DIGIT_W-1:0] pk_digits;
   logic [NDW-1:0]          pk_ndig;

   always_comb begin
      pk_sat  = (st_data[NSTG].quot != '0);
      pk_ndig = NDW'(1);
      for (int i = 1; i < NSTG; i++) begin
         if (st_digits[NSTG][i*DIGIT_W +: DIGIT_W] != '0) begin
            pk_ndig = NDW'(i + 1);
         end
      end
      pk_digits = st_digits[NSTG];
      if (pk_sat) begin
         pk_ndig   = NDW'(NSTG);
         pk_digits = {NSTG{DIGIT_NINE}};
      end
   end

   // serializer
   logic                    busy_ff, busy_in;
   logic                    sign_ff, sign_in;
   logic [NSTG*DIGIT_W-1:0] digits_ff, digits_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic [COUNT_W-1:0]      total_ff, total_in;
   logic                    out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]       out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;
   logic [COUNT_W-1:0]      out_count_ff, out_count_in;
   logic                    ser_load;
   logic                    emit;
   logic [DIGIT_W-1:0]      cur_digit;

   assign st_ready[NSTG+1] = !busy_ff;
   assign ser_load  = !busy_ff && st_valid[NSTG];
   assign emit      = busy_ff && (!out_valid_ff || !rsp_stall);
   assign cur_digit = digits_ff[pos_ff*DIGIT_W +: DIGIT_W];

   always_comb begin
      busy_in      = busy_ff;
      sign_in      = sign_ff;
      digits_in    = digits_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_count_in = out_count_ff;
      if (ser_load) begin
         busy_in   = 1'b1;
         sign_in   = st_data[NSTG].neg;
         digits_in = pk_digits;
         pos_in    = PW'(pk_ndig - NDW'(1));
         total_in  = COUNT_W'(pk_ndig) + COUNT_W'(st_data[NSTG].neg);
      end else if (emit) begin
         out_valid_in = 1'b1;
         if (sign_ff) begin
            sign_in      = 1'b0;
            out_char_in  = CH_MINUS;
            out_last_in  = 1'b0;
            out_count_in = '0;
         end else begin
            out_char_in  = CH_ZERO + CHAR_W'(cur_digit);
            out_last_in  = (pos_ff == '0);
            out_count_in = (pos_ff == '0) ? total_ff : '0;
            if (pos_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               pos_in = pos_ff - PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff      <= sign_in;
      digits_ff    <= digits_in;
      pos_ff       <= pos_in;
      total_ff     <= total_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_character  = out_char_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_char_count = out_count_ff;

   // checks
   a_last_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_char_count != '0)
      else $error("last word without a character count");

   a_mid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_char_count == '0)
      else $error("character count on a word that is not last");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CH_MINUS |-> !rsp_last)
      else $error("minus sign marked as last");

   a_final_digit: assert property (@(posedge clock) disable iff (reset)
      emit && !sign_ff && pos_ff == '0 |=> rsp_valid && rsp_last && !busy_ff)
      else $error("final digit not flagged as last");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ser_load)
      else $error("serializer loaded while busy");

endmodule

// ----- sim/tb_signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
   import sida_pkg::*;

   localparam int DIGITS_MAX  = 10;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_N    = 450;
   localparam int DIR_N       = 20;

   typedef struct packed {
      logic [CHAR_W-1:0]  character;
      logic               last;
      logic [COUNT_W-1:0] char_count;
   } text_char_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;
   logic [COUNT_W-1:0]  rsp_char_count;

   text_char_type pending_chars[$];
   int            failures = 0;
   int            cycle_count = 0;
   int            stall_left = 0;
   bit            calm = 1'b0;
   bit            hold_request = 1'b0;

   // directed words; a non-empty string is the expected text
   logic signed [VALUE_W-1:0] dir_value [DIR_N] = '{
      0, 1, -1, 9, 10, -10, 99, 100, -999, 1000,
      999999999, 1000000000, -1000000000, 2147483647, 32'sh8000_0000,
      -2147483647, 123456789, -987654321, 2147483640, 32'sh4000_0000
   };
   string dir_text [DIR_N] = '{
      "0", "1", "-1", "9", "10", "-10", "", "", "", "",
      "", "1000000000", "-1000000000", "2147483647", "-2147483648",
      "-2147483647", "", "", "", ""
   };

   signed_int_to_decimal_ascii #(.MAX_DIGITS(DIGITS_MAX)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .rsp_char_count (rsp_char_count)
   );

   always #2 clock = ~clock;

   // queue the characters expected for one value
   function automatic void predict_text(input logic [VALUE_W-1:0] v);
      logic               neg;
      logic [VALUE_W-1:0] mag;
      logic [3:0]         dig [20];
      int                 n;
      int                 total;
      text_char_type      c;
      neg = v[VALUE_W-1];
      mag = neg ? (32'd0 - v) : v;
      n = 0;
      do begin
         dig[n] = 4'(mag % RADIX);
         mag = mag / RADIX;
         n++;
      end while (mag != 0 && n < DIGITS_MAX);
      if (mag != 0)
         for (int i = 0; i < n; i++) dig[i] = DIGIT_NINE;
      total = n + (neg ? 1 : 0);
      if (neg) begin
         c.character = CH_MINUS;
         c.last = 1'b0;
         c.char_count = '0;
         pending_chars.push_back(c);
      end
      for (int i = n - 1; i >= 0; i--) begin
         c.character = CH_ZERO + CHAR_W'(dig[i]);
         c.last = (i == 0);
         c.char_count = (i == 0) ? COUNT_W'(total) : '0;
         pending_chars.push_back(c);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // mostly values of a random digit count, some raw words, some near 10^k
   function automatic logic [VALUE_W-1:0] random_value();
      int unsigned lo;
      int unsigned hi;
      int unsigned mag;
      int unsigned nd;
      int unsigned kind;
      logic        neg;
      kind = $urandom_range(0, 9);
      neg = 1'($urandom_range(0, 1));
      if (kind < 3) return $urandom();
      nd = $urandom_range(1, 10);
      lo = 1;
      for (int k = 1; k < nd; k++) lo = lo * 10;
      if (kind < 8) begin
         hi = (nd == 10) ? (neg ? 32'h8000_0000 : 32'h7fff_ffff) : lo * 10 - 1;
         if (nd == 1) lo = 0;
         mag = $urandom_range(hi, lo);
      end else begin
         mag = lo - 1 + $urandom_range(0, 2);
      end
      return neg ? (32'd0 - mag) : mag;
   endfunction

   task automatic send_word(input logic [VALUE_W-1:0] v);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin : check_words
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected word: rsp_character %0d", rsp_character);
            failures++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_character !== want.character) begin
               $error("rsp_character: expected %0d, got %0d",
                      want.character, rsp_character);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0d, got %0d", want.last, rsp_last);
               failures++;
            end
            if (rsp_char_count !== want.char_count) begin
               $error("rsp_char_count: expected %0d, got %0d",
                      want.char_count, rsp_char_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [VALUE_W-1:0] v;
      text_char_type      c;
      string              s;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++) begin
         send_word(dir_value[i]);
         s = dir_text[i];
         if (s.len() == 0) begin
            predict_text(dir_value[i]);
         end else begin
            for (int k = 0; k < s.len(); k++) begin
               c.character = s[k];
               c.last = (k == s.len() - 1);
               c.char_count = c.last ? COUNT_W'(s.len()) : '0;
               pending_chars.push_back(c);
            end
         end
      end

      // back-pressure: receiver holds off while words keep coming
      for (int n = 0; n < RANDOM_N; n++) begin
         if (n == 150) begin
            calm = 1'b1;
            hold_request = 1'b1;
         end
         if (n == 230) calm = 1'b0;
         v = random_value();
         send_word(v);
         predict_text(v);
      end
      req_valid <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- signed_int_to_decimal_ascii.f -----
hdl/sida_pkg.sv
hdl/sida_digit_stage.sv
hdl/signed_int_to_decimal_ascii.sv
sim/tb_signed_int_to_decimal_ascii.sv
